[rtl/rvp_pkg.sv]
// rvp_pkg: shared types, widths and register codes for the radial vignette pixel unit
// no dependencies; imported by every module under rtl/

package rvp_pkg;

    localparam int POS_W        = 12;
    localparam int CHAN_W       = 8;
    localparam int CFG_DIM_W    = 13;
    localparam int STRENGTH_W   = 17;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int MAG_W        = 13;
    localparam int MAG_SQ_W     = 2 * MAG_W;
    localparam int QUO_W        = 17;
    localparam int D2_W         = 17;
    localparam int LOSS_W       = 18;
    localparam int GAIN_W       = 17;

    // restoring divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int FRONT_LAT    = 2;
    localparam int SCALE_LAT    = 4;
    localparam int PIPE_LAT     = FRONT_LAT + DIV_STAGES + SCALE_LAT;

    localparam int DEFAULT_MAX_DIM = 4096;
    localparam int RST_WIDTH       = 640;
    localparam int RST_HEIGHT      = 480;
    localparam int RST_STRENGTH    = 32768;

    localparam logic [D2_W-1:0] Q16_ONE = D2_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_STRENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } result_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // distance from center on one axis, ovf set when the term alone reaches 2.0
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             ovf;
    } mag_t;

    typedef struct packed {
        logic [MAG_SQ_W-1:0] mag_sq;
        logic                ovf;
    } axis_t;

    typedef struct packed {
        axis_t ax;
        axis_t ay;
        rgb_t  rgb;
    } front_t;

    // control carried along the divider chain
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [1:0]       low;
        logic             ovf;
    } div_ctl_t;

    typedef struct packed {
        logic [QUO_W-1:0] quo_x;
        logic             ovf_x;
        logic [QUO_W-1:0] quo_y;
        logic             ovf_y;
        rgb_t             rgb;
    } scale_in_t;

endpackage

[rtl/radial_vignette_pixel_unit.sv]
// radial_vignette_pixel_unit: top level, configuration registers and the full pipeline
// depends on rvp_pkg, rvp_front, rvp_div_stage, rvp_scale
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------------
//  pixel    | start, busy, pixel             | word taken when start && !busy
//  result   | done, result                   | word valid for one cycle with done
//  config   | wr_en, wr_index, wr_data       | register written when wr_en is high
//
// one pixel per clock; each word passes the front, divider and scale stages in turn
// (2 front + 9 divider + 4 scale stages at the default step count per divider stage)
// most of the depth comes from the 17-bit restoring division, two quotient bits per stage
// busy is never raised and the receiver cannot stall, so the pipeline never holds
// reset clears the valid chain and loads width 640, height 480, strength 32768

module radial_vignette_pixel_unit
    import rvp_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pixel_t                pixel,
    output logic                  done,
    output result_t               result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    // a 13-bit register never holds more than 8191
    localparam int EFF_DIM = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int DIM_W   = $clog2(EFF_DIM + 1);
    localparam int DSQ_W   = 2 * DIM_W;
    localparam int REM_W   = DSQ_W + 1;
    localparam int WIDE_W  = REM_W + MAG_SQ_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > CFG_DIM_W'(EFF_DIM))
            return DIM_W'(EFF_DIM);
        else
            return v[DIM_W-1:0];
    endfunction

    localparam logic [DIM_W-1:0] RST_DIM_W = clamp_dim(CFG_DIM_W'(RST_WIDTH));
    localparam logic [DIM_W-1:0] RST_DIM_H = clamp_dim(CFG_DIM_W'(RST_HEIGHT));
    localparam logic [DSQ_W-1:0] RST_SQ_W  = DSQ_W'(RST_DIM_W) * DSQ_W'(RST_DIM_W);
    localparam logic [DSQ_W-1:0] RST_SQ_H  = DSQ_W'(RST_DIM_H) * DSQ_W'(RST_DIM_H);

    logic [DIM_W-1:0]      dim_w_reg, dim_h_reg;
    logic [DSQ_W-1:0]      sq_w_reg, sq_h_reg;
    logic [STRENGTH_W-1:0] strength_reg;
    logic [DIM_W-1:0]      wr_dim;
    logic [DSQ_W-1:0]      wr_sq;

    logic                  accept;
    logic                  vld_reg [PIPE_LAT];
    front_t                front_word;
    rgb_t                  rgb_dly_reg [DIV_STAGES];
    logic [WIDE_W-1:0]     rem_x_wide, rem_y_wide;
    logic [REM_W-1:0]      rem_x_chain [DIV_STAGES+1];
    logic [REM_W-1:0]      rem_y_chain [DIV_STAGES+1];
    div_ctl_t              ctl_x_chain [DIV_STAGES+1];
    div_ctl_t              ctl_y_chain [DIV_STAGES+1];
    scale_in_t             scale_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // clamp and square at write time so the datapath sees settled values next cycle
    assign wr_dim = clamp_dim(wr_data[CFG_DIM_W-1:0]);
    assign wr_sq  = DSQ_W'(wr_dim) * DSQ_W'(wr_dim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_w_reg    <= RST_DIM_W;
            dim_h_reg    <= RST_DIM_H;
            sq_w_reg     <= RST_SQ_W;
            sq_h_reg     <= RST_SQ_H;
            strength_reg <= STRENGTH_W'(RST_STRENGTH);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH:
                begin
                    dim_w_reg <= wr_dim;
                    sq_w_reg  <= wr_sq;
                end
                REG_HEIGHT:
                begin
                    dim_h_reg <= wr_dim;
                    sq_h_reg  <= wr_sq;
                end
                REG_STRENGTH:
                begin
                    strength_reg <= wr_data[STRENGTH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // valid bits ride alongside the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < PIPE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    rvp_front #(
        .DIM_W (DIM_W)
    ) u_front (
        .clk   (clk),
        .dim_w (dim_w_reg),
        .dim_h (dim_h_reg),
        .pixel (pixel),
        .word  (front_word)
    );

    // divider starts from mag^2 >> 2, already below dim^2 unless the axis overflows
    assign rem_x_wide     = WIDE_W'(front_word.ax.mag_sq >> 2);
    assign rem_y_wide     = WIDE_W'(front_word.ay.mag_sq >> 2);
    assign rem_x_chain[0] = rem_x_wide[REM_W-1:0];
    assign rem_y_chain[0] = rem_y_wide[REM_W-1:0];
    assign ctl_x_chain[0] = '{quo: '0, low: front_word.ax.mag_sq[1:0], ovf: front_word.ax.ovf};
    assign ctl_y_chain[0] = '{quo: '0, low: front_word.ay.mag_sq[1:0], ovf: front_word.ay.ovf};

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        rvp_div_stage #(
            .DIM_W (DIM_W),
            .STAGE (s)
        ) u_div_x (
            .d_sq    (sq_w_reg),
            .clk     (clk),
            .rem_in  (rem_x_chain[s]),
            .ctl_in  (ctl_x_chain[s]),
            .rem_out (rem_x_chain[s+1]),
            .ctl_out (ctl_x_chain[s+1])
        );

        rvp_div_stage #(
            .DIM_W (DIM_W),
            .STAGE (s)
        ) u_div_y (
            .d_sq    (sq_h_reg),
            .clk     (clk),
            .rem_in  (rem_y_chain[s]),
            .ctl_in  (ctl_y_chain[s]),
            .rem_out (rem_y_chain[s+1]),
            .ctl_out (ctl_y_chain[s+1])
        );
    end

    always_ff @(posedge clk)
    begin
        rgb_dly_reg[0] <= front_word.rgb;
        for (int i = 1; i < DIV_STAGES; i++)
            rgb_dly_reg[i] <= rgb_dly_reg[i-1];
    end

    assign scale_word = '{
        quo_x: ctl_x_chain[DIV_STAGES].quo,
        ovf_x: ctl_x_chain[DIV_STAGES].ovf,
        quo_y: ctl_y_chain[DIV_STAGES].quo,
        ovf_y: ctl_y_chain[DIV_STAGES].ovf,
        rgb:   rgb_dly_reg[DIV_STAGES-1]
    };

    rvp_scale u_scale (
        .clk      (clk),
        .strength (strength_reg),
        .word_in  (scale_word),
        .result   (result)
    );

    assign done = vld_reg[PIPE_LAT-1];

    // every word taken raises done once it has passed through the whole pipeline
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("accepted word did not leave on time");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_LAT))
        else $error("result strobe without a matching accepted word");

    // a black pixel stays black whatever the gain; checks the color delay alignment
    a_black_stays_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(pixel.red_in == '0 && pixel.green_in == '0
                       && pixel.blue_in == '0, PIPE_LAT))
        |-> (result == '0))
        else $error("black pixel came out nonzero");

endmodule

[rtl/rvp_front.sv]
// rvp_front: distance from image center per axis, then squared, two register stages
// depends on rvp_pkg

module rvp_front
    import rvp_pkg::*;
#(
    parameter int DIM_W = 13
)
(
    input  logic             clk,
    input  logic [DIM_W-1:0] dim_w,
    input  logic [DIM_W-1:0] dim_h,
    input  pixel_t           pixel,
    output front_t           word
);

    mag_t   mag_x_reg, mag_x_next;
    mag_t   mag_y_reg, mag_y_next;
    rgb_t   rgb_reg;
    front_t word_reg, word_next;

    // |2p+1-d|, overflow when it reaches 2d (term at or above 2.0)
    function automatic mag_t axis_dist(input logic [POS_W-1:0] p, input logic [DIM_W-1:0] d);
        logic [MAG_W-1:0] twice;
        logic [MAG_W-1:0] dz;
        mag_t             r;
        twice = {p, 1'b1};
        dz    = MAG_W'(d);
        r.mag = (twice >= dz) ? (twice - dz) : (dz - twice);
        r.ovf = ({1'b0, r.mag} >= {dz, 1'b0});
        return r;
    endfunction

    always_comb
    begin
        mag_x_next = axis_dist(pixel.pos_x, dim_w);
        mag_y_next = axis_dist(pixel.pos_y, dim_h);
    end

    always_comb
    begin
        word_next.ax.mag_sq = MAG_SQ_W'(mag_x_reg.mag) * MAG_SQ_W'(mag_x_reg.mag);
        word_next.ax.ovf    = mag_x_reg.ovf;
        word_next.ay.mag_sq = MAG_SQ_W'(mag_y_reg.mag) * MAG_SQ_W'(mag_y_reg.mag);
        word_next.ay.ovf    = mag_y_reg.ovf;
        word_next.rgb       = rgb_reg;
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        rgb_reg   <= '{red: pixel.red_in, green: pixel.green_in, blue: pixel.blue_in};
        word_reg  <= word_next;
    end

    assign word = word_reg;

endmodule

[rtl/rvp_div_stage.sv]
// rvp_div_stage: one register stage of the restoring divider mag^2*2^15 / dim^2
// depends on rvp_pkg; chained in the top level

module rvp_div_stage
    import rvp_pkg::*;
#(
    parameter int DIM_W = 13,
    parameter int STAGE = 0
)
(
    input  logic [2*DIM_W-1:0] d_sq,
    input  logic               clk,
    input  logic [2*DIM_W:0]   rem_in,
    input  div_ctl_t           ctl_in,
    output logic [2*DIM_W:0]   rem_out,
    output div_ctl_t           ctl_out
);

    localparam int REM_W = 2 * DIM_W + 1;

    logic [REM_W-1:0] rem_reg, rem_next;
    div_ctl_t         ctl_reg, ctl_next;

    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] divisor;
        logic             nb;
        int               k;
        divisor  = REM_W'(d_sq);
        rem_next = rem_in;
        ctl_next = ctl_in;
        trial    = '0;
        nb       = 1'b0;
        k        = 0;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            k = STAGE * DIV_STEPS + j;
            if (k < QUO_W)
            begin
                // only the two low bits of mag^2 remain; the 2^15 scale shifts in zeros
                nb = (k == 0) ? ctl_in.low[1] : ((k == 1) ? ctl_in.low[0] : 1'b0);
                trial = {rem_next[REM_W-2:0], nb};
                if (trial >= divisor)
                begin
                    rem_next     = trial - divisor;
                    ctl_next.quo = {ctl_next.quo[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next     = trial;
                    ctl_next.quo = {ctl_next.quo[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        ctl_reg <= ctl_next;
    end

    assign rem_out = rem_reg;
    assign ctl_out = ctl_reg;

endmodule

[rtl/rvp_scale.sv]
// rvp_scale: distance sum, strength loss, gain and per-channel rounding, four stages
// depends on rvp_pkg

module rvp_scale
    import rvp_pkg::*;
(
    input  logic                  clk,
    input  logic [STRENGTH_W-1:0] strength,
    input  scale_in_t             word_in,
    output result_t               result
);

    localparam int PROD_W  = STRENGTH_W + D2_W;
    localparam int CHAN_PW = CHAN_W + GAIN_W + 1;

    logic [D2_W-1:0]   d2_reg, d2_next;
    logic [LOSS_W-1:0] loss_reg, loss_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    rgb_t              rgb1_reg, rgb2_reg, rgb3_reg;
    result_t           result_reg, result_next;

    // (c*f + half) >> 16, saturated to a channel
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [GAIN_W-1:0] f);
        logic [CHAN_PW-1:0] v;
        v = CHAN_PW'(c) * CHAN_PW'(f) + CHAN_PW'(32768);
        return (v[CHAN_PW-1:16] > (CHAN_PW-16)'(255)) ? '1 : v[16 +: CHAN_W];
    endfunction

    always_comb
    begin
        logic [D2_W:0]     sum;
        logic [PROD_W-1:0] prod;
        sum  = (D2_W+1)'(word_in.quo_x) + (D2_W+1)'(word_in.quo_y);
        if (word_in.ovf_x || word_in.ovf_y || sum > (D2_W+1)'(Q16_ONE))
            d2_next = Q16_ONE;
        else
            d2_next = sum[D2_W-1:0];

        prod      = PROD_W'(strength) * PROD_W'(d2_reg);
        loss_next = prod[16 +: LOSS_W];

        if (loss_reg >= LOSS_W'(Q16_ONE))
            gain_next = '0;
        else
            gain_next = GAIN_W'(LOSS_W'(Q16_ONE) - loss_reg);

        result_next.red_out   = scale_chan(rgb3_reg.red,   gain_reg);
        result_next.green_out = scale_chan(rgb3_reg.green, gain_reg);
        result_next.blue_out  = scale_chan(rgb3_reg.blue,  gain_reg);
    end

    always_ff @(posedge clk)
    begin
        d2_reg     <= d2_next;
        loss_reg   <= loss_next;
        gain_reg   <= gain_next;
        rgb1_reg   <= word_in.rgb;
        rgb2_reg   <= rgb1_reg;
        rgb3_reg   <= rgb2_reg;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[bench/testbench.sv]
// testbench: directed and random pixels through radial_vignette_pixel_unit, checked
// word by word against a bit-exact vignette predictor held in a small scoreboard class
// depends on rvp_pkg and the rtl under rtl/

module testbench;
    import rvp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_REPORTS = 10;

    class vignette_scoreboard;
        result_t             darkened_q[$];
        int unsigned         failures;
        bit [CFG_DIM_W-1:0]  width_reg;
        bit [CFG_DIM_W-1:0]  height_reg;
        bit [STRENGTH_W-1:0] strength_reg;

        function new();
            failures     = 0;
            width_reg    = CFG_DIM_W'(RST_WIDTH);
            height_reg   = CFG_DIM_W'(RST_HEIGHT);
            strength_reg = STRENGTH_W'(RST_STRENGTH);
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH:    width_reg = data[CFG_DIM_W-1:0];
                REG_HEIGHT:   height_reg = data[CFG_DIM_W-1:0];
                REG_STRENGTH: strength_reg = data[STRENGTH_W-1:0];
                default:      ;
            endcase
        endfunction

        function longint unsigned clamp_dim(bit [CFG_DIM_W-1:0] d);
            if (d == 0)
                return 64'(1);
            if (d > DEFAULT_MAX_DIM)
                return 64'(DEFAULT_MAX_DIM);
            return 64'(d);
        endfunction

        // floor(|2p+1-d|^2 * 32768 / d^2)
        function longint unsigned axis_q16(logic [POS_W-1:0] p, longint unsigned d);
            longint unsigned twice;
            longint unsigned mag;
            twice = 64'(p);
            twice = 2 * twice + 1;
            mag = (twice >= d) ? twice - d : d - twice;
            return (mag * mag * 32768) / (d * d);
        endfunction

        function logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] c, longint unsigned gain);
            longint unsigned v;
            v = 64'(c);
            v = (v * gain + 32768) >> 16;
            return (v > 255) ? 8'hFF : v[CHAN_W-1:0];
        endfunction

        function result_t darken(pixel_t p);
            longint unsigned d2;
            longint unsigned loss;
            longint unsigned gain;
            longint unsigned s;
            result_t         r;
            d2 = axis_q16(p.pos_x, clamp_dim(width_reg))
               + axis_q16(p.pos_y, clamp_dim(height_reg));
            if (d2 > 65536)
                d2 = 65536;
            s = 64'(strength_reg);
            loss = (s * d2) >> 16;
            gain = (loss >= 65536) ? 0 : 65536 - loss;
            r.red_out   = scale_chan(p.red_in, gain);
            r.green_out = scale_chan(p.green_in, gain);
            r.blue_out  = scale_chan(p.blue_in, gain);
            return r;
        endfunction

        function void note_pixel(pixel_t p);
            darkened_q.push_back(darken(p));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (darkened_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected word: r %0d g %0d b %0d",
                             got.red_out, got.green_out, got.blue_out);
                return;
            end
            want = darkened_q.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                             want.red_out, want.green_out, want.blue_out,
                             got.red_out, got.green_out, got.blue_out);
            end
        endfunction

        function int pending();
            return darkened_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    pixel_t                pixel = '0;
    logic                  done;
    result_t               result;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    vignette_scoreboard sb;
    int unsigned        idle_pct = 0;
    int unsigned        quiet_cycles = 0;

    radial_vignette_pixel_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel    (pixel),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // pre-edge values are seen here, so accepted words line up with the dut
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_pixel(pixel);
        if (rst_n && done)
            sb.check_result(result);
        if (rst_n && ((start && !busy) || done))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        pixel <= p;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // sender holds off until every outstanding word is back
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        sb.apply_write(idx, data);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                              logic [CFG_DATA_W-1:0] s, bit spare);
        drain_pipe();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_STRENGTH, s);
        if (spare)
            write_reg(REG_SPARE, 17'h1ABCD);
        wr_en <= 1'b0;
    endtask

    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(19, 0))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return CHAN_W'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic run_phase(int n);
        pixel_t          p;
        longint unsigned w;
        longint unsigned h;
        w = sb.clamp_dim(sb.width_reg);
        h = sb.clamp_dim(sb.height_reg);
        repeat (n)
        begin
            // mostly inside the image, the rest anywhere in the 12-bit range
            if ($urandom_range(99, 0) < 85)
            begin
                p.pos_x = POS_W'($urandom_range(32'(w - 1), 0));
                p.pos_y = POS_W'($urandom_range(32'(h - 1), 0));
            end
            else
            begin
                p.pos_x = POS_W'($urandom_range(4095, 0));
                p.pos_y = POS_W'($urandom_range(4095, 0));
            end
            p.red_in   = pick_chan();
            p.green_in = pick_chan();
            p.blue_in  = pick_chan();
            send_pixel(p);
        end
    endtask

    initial
    begin
        sb = new();
        idle_pct = 9;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry 640x480: center, corners, edges, outside the image
        send_pixel(pixel_t'{12'd319, 12'd239, 8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{12'd320, 12'd240, 8'd255, 8'd128, 8'd0});
        send_pixel(pixel_t'{12'd0, 12'd0, 8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{12'd639, 12'd479, 8'd255, 8'd1, 8'd0});
        send_pixel(pixel_t'{12'd639, 12'd0, 8'd128, 8'd127, 8'd64});
        send_pixel(pixel_t'{12'd0, 12'd479, 8'd1, 8'd2, 8'd3});
        send_pixel(pixel_t'{12'd0, 12'd239, 8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{12'd319, 12'd0, 8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{12'd640, 12'd480, 8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{12'd4095, 12'd0, 8'd200, 8'd100, 8'd50});
        send_pixel(pixel_t'{12'd0, 12'd4095, 8'd0, 8'd0, 8'd0});
        send_pixel(pixel_t'{12'd2730, 12'd1365, 8'd170, 8'd85, 8'd255});
        send_pixel(pixel_t'{12'd480, 12'd360, 8'd255, 8'd0, 8'd255});
        send_pixel(pixel_t'{12'd160, 12'd120, 8'd0, 8'd255, 8'd0});
        send_pixel(pixel_t'{12'd1, 12'd1, 8'd254, 8'd253, 8'd252});
        run_phase(PHASE_ITEMS);

        // extremes: tiny image, full size, zero dimension, oversized, strength above 1.0
        set_config(17'd1, 17'd1, 17'd65536, 1'b0);
        run_phase(PHASE_ITEMS);
        set_config(17'd4096, 17'd4096, 17'h1FFFF, 1'b0);
        run_phase(PHASE_ITEMS);
        set_config(17'd0, 17'd0, 17'd0, 1'b0);
        run_phase(PHASE_ITEMS);
        idle_pct = 63;
        set_config(17'd8191, 17'd6000, 17'd65535, 1'b0);
        run_phase(PHASE_ITEMS);
        set_config(17'd2, 17'd3, 17'd1, 1'b0);
        run_phase(PHASE_ITEMS);
        // upper data bits beyond the width register are dropped
        set_config(17'h10007, 17'd4096, 17'd98304, 1'b1);
        run_phase(PHASE_ITEMS);

        for (int k = 0; k < 4; k++)
        begin
            idle_pct = (k == 0) ? 63 : 0;
            set_config(CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(16, 1)
                                                               : $urandom_range(4096, 1)),
                       CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(16, 1)
                                                               : $urandom_range(4096, 1)),
                       CFG_DATA_W'($urandom_range(131071, 0)), k == 1);
            run_phase(PHASE_ITEMS);
        end

        drain_pipe();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
